// ----- sv/wall_column_span_clipper_core_defines.svh -----
// Assertion macros shared by the span clipper checker.
// Expects clk and rst in the scope where the macros are used.
`ifndef WALL_COLUMN_SPAN_CLIPPER_CORE_DEFINES_SVH
`define WALL_COLUMN_SPAN_CLIPPER_CORE_DEFINES_SVH

// Same-edge implication with no reset gating, for checks on reset itself.
`define WCSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// Same-edge implication, gated off while reset is high.
`define WCSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-edge implication, gated off while reset is high.
`define WCSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/wcsc_pkg.sv -----
// Shared types and constants for the wall column span clipper.
// No dependencies; used by the core and its checker.
`default_nettype none

package wcsc_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 1024;

  localparam int CW   = $clog2(SCREEN_WIDTH);   // window store address
  localparam int YW   = $clog2(SCREEN_HEIGHT);  // window row width
  localparam int SPW  = YW + 2;                 // signed span bound
  localparam int Y_W  = 10;                     // row fields of a span item
  localparam int QW   = 16;                     // quotient and divisor width
  localparam int PW   = 2 * QW;                 // product width
  localparam int HW   = QW + 2;                 // interpolated height, signed
  localparam int DIV_BITS  = 4;                 // quotient bits per cycle
  localparam int DIV_STEPS = QW / DIV_BITS;
  localparam int DSW  = $clog2(DIV_STEPS);

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_SOLID  = 2'd1;
  localparam logic [1:0] MODE_PORTAL = 2'd2;

  localparam logic [2:0] KIND_CEIL  = 3'd0;
  localparam logic [2:0] KIND_FLOOR = 3'd1;
  localparam logic [2:0] KIND_WALL  = 3'd2;
  localparam logic [2:0] KIND_UPPER = 3'd3;
  localparam logic [2:0] KIND_LOWER = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_POST,
    ST_EMIT,
    ST_WB
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         column;
    logic signed [15:0] x_start;
    logic signed [15:0] x_end;
    logic signed [15:0] ceil_start;
    logic signed [15:0] ceil_end;
    logic signed [15:0] floor_start;
    logic signed [15:0] floor_end;
    logic signed [15:0] nb_ceil_start;
    logic signed [15:0] nb_ceil_end;
    logic signed [15:0] nb_floor_start;
    logic signed [15:0] nb_floor_end;
  } item_t;

  typedef struct packed {
    logic [9:0]     span_column;
    logic [2:0]     span_kind;
    logic           visible;
    logic [Y_W-1:0] y_first;
    logic [Y_W-1:0] y_last;
    logic           last;
  } span_t;

  typedef struct packed {
    logic [YW-1:0] top;
    logic [YW-1:0] bot;
  } win_t;

endpackage

`default_nettype wire

// ----- sv/wall_column_span_clipper_core.sv -----
// Span clipper core: per-column height interpolation, window clamp, span output.
// Depends on wcsc_pkg. Column windows live in one synchronous RAM.
// Sequence: a wall item passes READ, then DIV and POST for each height (two for a
// solid item, four for a portal), then EMIT for its spans and, for a portal, WB.
// Clear and ignored items are taken in IDLE. Shared divider, 4 bits a cycle.
// Reset: window clearing pass over SCREEN_WIDTH columns, stall held high meanwhile.
`default_nettype none

module wall_column_span_clipper_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  wcsc_pkg::item_t item,
  output logic            span_valid,
  input  logic            span_stall,
  output wcsc_pkg::span_t span
);

  localparam logic [wcsc_pkg::YW-1:0] HMAX = wcsc_pkg::YW'(wcsc_pkg::SCREEN_HEIGHT - 1);

  wcsc_pkg::state_t state, state_next;

  // window store
  wcsc_pkg::win_t             win_mem [wcsc_pkg::SCREEN_WIDTH];
  wcsc_pkg::win_t             win_rd;
  wcsc_pkg::win_t             win_wr;
  logic                       win_we;
  logic [wcsc_pkg::CW-1:0]    win_waddr;
  logic [wcsc_pkg::CW-1:0]    init_addr;

  wcsc_pkg::item_t            cur;
  logic [wcsc_pkg::QW-1:0]    t_off;
  logic [wcsc_pkg::QW-1:0]    dx;
  logic [wcsc_pkg::YW-1:0]    top, bot;
  logic [1:0]                 hidx, eidx;
  logic [wcsc_pkg::PW-1:0]    prod, prod_next;
  logic                       prod_neg;
  logic [wcsc_pkg::QW-1:0]    rem, dq, rem_next, dq_next;
  logic [wcsc_pkg::DSW-1:0]   dstep;
  logic [wcsc_pkg::YW-1:0]    hgt [4];

  logic                       accept, col_ok, draw_ok, is_portal;
  logic signed [16:0]         col_x, x1_x, x2_x, t_x, dx_x;
  logic [1:0]                 mul_idx, last_h, last_e;
  logic signed [15:0]         hs_mul, he_mul, hs_post;
  logic signed [16:0]         dh, dh_inv;
  logic [wcsc_pkg::QW-1:0]    dh_mag;
  logic [wcsc_pkg::QW-1:0]    div_r, div_d;
  logic [wcsc_pkg::QW:0]      div_trial;
  logic signed [wcsc_pkg::HW-1:0] qs, hv, hc, top_x, bot_x;
  logic [wcsc_pkg::YW-1:0]    hnew;
  logic [wcsc_pkg::YW-1:0]    mx, mn, new_top, new_bot;
  logic signed [wcsc_pkg::SPW-1:0] y1, y2;
  logic [wcsc_pkg::YW-1:0]    yc1, yc2;
  logic [2:0]                 kind;
  logic                       load;
  wcsc_pkg::span_t            span_next;

  function automatic logic signed [15:0] pick_h(input wcsc_pkg::item_t it,
                                                input logic [1:0] idx,
                                                input logic at_end);
    logic signed [15:0] v;
    case (idx)
      2'd0:    v = at_end ? it.ceil_end      : it.ceil_start;
      2'd1:    v = at_end ? it.floor_end     : it.floor_start;
      2'd2:    v = at_end ? it.nb_ceil_end   : it.nb_ceil_start;
      default: v = at_end ? it.nb_floor_end  : it.nb_floor_start;
    endcase
    return v;
  endfunction

  function automatic logic signed [wcsc_pkg::SPW-1:0] ext_y(input logic [wcsc_pkg::YW-1:0] v);
    return $signed({2'b00, v});
  endfunction

  function automatic logic [wcsc_pkg::YW-1:0] clamp_y(
      input logic signed [wcsc_pkg::SPW-1:0] v);
    logic [wcsc_pkg::YW-1:0] r;
    if (v < $signed(wcsc_pkg::SPW'(0))) begin
      r = '0;
    end else if (v > ext_y(HMAX)) begin
      r = HMAX;
    end else begin
      r = v[wcsc_pkg::YW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- input check
  assign accept    = item_valid && !item_stall;
  assign col_ok    = int'(item.column) < wcsc_pkg::SCREEN_WIDTH;
  assign col_x     = $signed({7'b0, item.column});
  assign x1_x      = {item.x_start[15], item.x_start};
  assign x2_x      = {item.x_end[15], item.x_end};
  assign t_x       = col_x - x1_x;
  assign dx_x      = x2_x - x1_x;
  assign draw_ok   = col_ok
                  && (item.mode == wcsc_pkg::MODE_SOLID || item.mode == wcsc_pkg::MODE_PORTAL)
                  && (x1_x < x2_x) && (col_x >= x1_x) && (col_x <= x2_x);
  assign is_portal = (cur.mode == wcsc_pkg::MODE_PORTAL);
  assign last_h    = is_portal ? 2'd3 : 2'd1;
  assign last_e    = is_portal ? 2'd3 : 2'd2;

  // ---------------------------------------------------------------- multiplier
  // Product of offset and height delta magnitude for the next height to divide.
  assign mul_idx   = (state == wcsc_pkg::ST_READ) ? 2'd0 : hidx + 2'd1;
  assign hs_mul    = pick_h(cur, mul_idx, 1'b0);
  assign he_mul    = pick_h(cur, mul_idx, 1'b1);
  assign dh        = {he_mul[15], he_mul} - {hs_mul[15], hs_mul};
  assign dh_inv    = -dh;
  assign dh_mag    = dh[16] ? dh_inv[wcsc_pkg::QW-1:0] : dh[wcsc_pkg::QW-1:0];
  assign prod_next = t_off * dh_mag;

  // ---------------------------------------------------------------- divider
  // Restoring division; the quotient never exceeds the delta magnitude, so the
  // upper product half is already below the divisor.
  always_comb begin
    div_r     = (dstep == '0) ? prod[wcsc_pkg::PW-1:wcsc_pkg::QW] : rem;
    div_d     = (dstep == '0) ? prod[wcsc_pkg::QW-1:0] : dq;
    div_trial = '0;
    for (int i = 0; i < wcsc_pkg::DIV_BITS; i++) begin
      div_trial = {div_r, div_d[wcsc_pkg::QW-1]};
      div_d     = {div_d[wcsc_pkg::QW-2:0], 1'b0};
      if (div_trial >= {1'b0, dx}) begin
        div_trial = div_trial - {1'b0, dx};
        div_d[0]  = 1'b1;
      end
      div_r = div_trial[wcsc_pkg::QW-1:0];
    end
    rem_next = div_r;
    dq_next  = div_d;
  end

  // ---------------------------------------------------------------- height post
  // Restore sign (truncation toward zero), add start height, clamp into window.
  always_comb begin
    hs_post = pick_h(cur, hidx, 1'b0);
    qs      = $signed({2'b00, dq});
    hv      = (prod_neg ? -qs : qs) + {{2{hs_post[15]}}, hs_post};
    top_x   = $signed({{(wcsc_pkg::HW - wcsc_pkg::YW){1'b0}}, top});
    bot_x   = $signed({{(wcsc_pkg::HW - wcsc_pkg::YW){1'b0}}, bot});
    hc      = hv;
    if (hc < top_x) begin
      hc = top_x;
    end
    if (hc > bot_x) begin
      hc = bot_x;
    end
    hnew = hc[wcsc_pkg::YW-1:0];
  end

  // ---------------------------------------------------------------- window update
  always_comb begin
    mx      = (hgt[0] > hgt[2]) ? hgt[0] : hgt[2];
    mn      = (hgt[1] < hgt[3]) ? hgt[1] : hgt[3];
    new_top = (mx < top) ? top : mx;
    new_bot = (mn > bot) ? bot : mn;
  end

  // ---------------------------------------------------------------- span build
  always_comb begin
    case (eidx)
      2'd0: begin
        kind = wcsc_pkg::KIND_CEIL;
        y1   = ext_y(top);
        y2   = ext_y(hgt[0]) - $signed(wcsc_pkg::SPW'(1));
      end
      2'd1: begin
        kind = wcsc_pkg::KIND_FLOOR;
        y1   = ext_y(hgt[1]) + $signed(wcsc_pkg::SPW'(1));
        y2   = ext_y(bot);
      end
      2'd2: begin
        kind = is_portal ? wcsc_pkg::KIND_UPPER : wcsc_pkg::KIND_WALL;
        y1   = ext_y(hgt[0]);
        y2   = is_portal ? ext_y(hgt[2]) - $signed(wcsc_pkg::SPW'(1)) : ext_y(hgt[1]);
      end
      default: begin
        kind = wcsc_pkg::KIND_LOWER;
        y1   = ext_y(hgt[3]) + $signed(wcsc_pkg::SPW'(1));
        y2   = ext_y(hgt[1]);
      end
    endcase
    yc1 = clamp_y(y1);
    yc2 = clamp_y(y2);
    span_next.span_column = cur.column;
    span_next.span_kind   = kind;
    span_next.visible     = (yc2 >= yc1);
    span_next.y_first     = wcsc_pkg::Y_W'(yc1);
    span_next.y_last      = wcsc_pkg::Y_W'(yc2);
    span_next.last        = (eidx == last_e);
  end

  assign load = (state == wcsc_pkg::ST_EMIT) && (!span_valid || !span_stall);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      wcsc_pkg::ST_INIT: begin
        if (init_addr == wcsc_pkg::CW'(wcsc_pkg::SCREEN_WIDTH - 1)) begin
          state_next = wcsc_pkg::ST_IDLE;
        end
      end
      wcsc_pkg::ST_IDLE: begin
        if (accept && draw_ok) begin
          state_next = wcsc_pkg::ST_READ;
        end
      end
      wcsc_pkg::ST_READ: begin
        state_next = wcsc_pkg::ST_DIV;
      end
      wcsc_pkg::ST_DIV: begin
        if (dstep == wcsc_pkg::DSW'(wcsc_pkg::DIV_STEPS - 1)) begin
          state_next = wcsc_pkg::ST_POST;
        end
      end
      wcsc_pkg::ST_POST: begin
        state_next = (hidx == last_h) ? wcsc_pkg::ST_EMIT : wcsc_pkg::ST_DIV;
      end
      wcsc_pkg::ST_EMIT: begin
        if (load && eidx == last_e) begin
          state_next = is_portal ? wcsc_pkg::ST_WB : wcsc_pkg::ST_IDLE;
        end
      end
      wcsc_pkg::ST_WB: begin
        state_next = wcsc_pkg::ST_IDLE;
      end
      default: begin
        state_next = wcsc_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    item_stall = (state != wcsc_pkg::ST_IDLE);
    win_we     = 1'b0;
    win_waddr  = wcsc_pkg::CW'(cur.column);
    win_wr     = '{top: new_top, bot: new_bot};
    case (state)
      wcsc_pkg::ST_INIT: begin
        win_we    = 1'b1;
        win_waddr = init_addr;
        win_wr    = '{top: '0, bot: HMAX};
      end
      wcsc_pkg::ST_IDLE: begin
        if (accept && item.mode == wcsc_pkg::MODE_CLEAR && col_ok) begin
          win_we    = 1'b1;
          win_waddr = wcsc_pkg::CW'(item.column);
          win_wr    = '{top: '0, bot: HMAX};
        end
      end
      wcsc_pkg::ST_WB: begin
        win_we = 1'b1;
      end
      default: begin
        win_we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- window RAM
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_wr;
    end
    win_rd <= win_mem[wcsc_pkg::CW'(item.column)];
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wcsc_pkg::ST_INIT;
      init_addr  <= '0;
      hidx       <= '0;
      eidx       <= '0;
      dstep      <= '0;
      span_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == wcsc_pkg::ST_INIT) begin
        init_addr <= init_addr + wcsc_pkg::CW'(1);
      end
      if (accept) begin
        hidx <= '0;
      end
      case (state)
        wcsc_pkg::ST_READ: begin
          dstep <= '0;
        end
        wcsc_pkg::ST_DIV: begin
          dstep <= dstep + wcsc_pkg::DSW'(1);
        end
        wcsc_pkg::ST_POST: begin
          hidx  <= hidx + 2'd1;
          dstep <= '0;
          eidx  <= '0;
        end
        wcsc_pkg::ST_EMIT: begin
          if (load) begin
            eidx <= eidx + 2'd1;
          end
        end
        default: begin
          dstep <= dstep;
        end
      endcase
      if (load) begin
        span_valid <= 1'b1;
      end else if (!span_stall) begin
        span_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (accept && draw_ok) begin
      cur   <= item;
      t_off <= t_x[wcsc_pkg::QW-1:0];
      dx    <= dx_x[wcsc_pkg::QW-1:0];
    end
    if (state == wcsc_pkg::ST_READ) begin
      top <= win_rd.top;
      bot <= win_rd.bot;
    end
    if (state == wcsc_pkg::ST_READ || state == wcsc_pkg::ST_POST) begin
      prod     <= prod_next;
      prod_neg <= dh[16];
    end
    if (state == wcsc_pkg::ST_DIV) begin
      rem <= rem_next;
      dq  <= dq_next;
    end
    if (state == wcsc_pkg::ST_POST) begin
      hgt[hidx] <= hnew;
    end
    if (load) begin
      span <= span_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/wcsc_checker.sv -----
// Port-level checker for the span clipper core, attached by bind.
// Depends on wcsc_pkg and wall_column_span_clipper_core_defines.svh.
`default_nettype none
`include "wall_column_span_clipper_core_defines.svh"

module wcsc_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            item_stall,
  input wire logic            span_valid,
  input wire logic            span_stall,
  input wire wcsc_pkg::span_t span
);

  // hold a stalled span
  `WCSC_ASSERT_NEXT(a_span_hold, span_valid && span_stall,
                    span_valid && $stable(span), "stalled span changed")

  `WCSC_ASSERT_SAME(a_visible, span_valid,
                    span.visible == (span.y_last >= span.y_first),
                    "visible flag disagrees with rows")

  // window clearing pass keeps the input stalled
  `WCSC_ASSERT_SAME(a_init_stall, $past(rst), item_stall, "item taken during window clearing")

  // spans of one column follow back to back
  `WCSC_ASSERT_NEXT(a_same_col, span_valid && !span_stall && !span.last,
                    span_valid && $stable(span.span_column), "column spans broken up")

  `WCSC_ASSERT_SAME(a_last_kind, span_valid && span.last,
                    span.span_kind == wcsc_pkg::KIND_WALL ||
                    span.span_kind == wcsc_pkg::KIND_LOWER,
                    "final span of wrong kind")

endmodule

bind wall_column_span_clipper_core wcsc_checker u_wcsc_checker (
  .clk        (clk),
  .rst        (rst),
  .item_stall (item_stall),
  .span_valid (span_valid),
  .span_stall (span_stall),
  .span       (span)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for wall_column_span_clipper_core: directed and random column items.
// It predicts the spans with its own copy of the column windows and checks each span item.
// Depends on wcsc_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    wcsc_pkg::item_t it;
    int              send_idle;
    int              rcv_stall;
    bit              drain;
  } pend_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            item_valid = 1'b0;
  logic            item_stall;
  wcsc_pkg::item_t item = '0;
  logic            span_valid;
  logic            span_stall = 1'b0;
  wcsc_pkg::span_t span;

  pend_t           pending[$];
  wcsc_pkg::span_t expected_spans[$];
  logic [wcsc_pkg::YW-1:0] win_top [wcsc_pkg::SCREEN_WIDTH];
  logic [wcsc_pkg::YW-1:0] win_bot [wcsc_pkg::SCREEN_WIDTH];
  int span_stall_pct = 0;
  int mismatches = 0;

  wall_column_span_clipper_core dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .span_valid (span_valid),
    .span_stall (span_stall),
    .span       (span)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("wall_column_span_clipper_core test failed");
    $finish;
  end

  function automatic longint clamp_row(input longint v, input longint lo, input longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Truncating division toward zero, as longint division does.
  function automatic longint lerp_height(input longint t, input longint dx,
                                         input longint hs, input longint he);
    return (t * (he - hs)) / dx + hs;
  endfunction

  function automatic void add_span(input logic [9:0] col, input logic [2:0] kind,
                                   input longint y1, input longint y2, input bit lst);
    wcsc_pkg::span_t s;
    longint          f, l;
    f = clamp_row(y1, 0, wcsc_pkg::SCREEN_HEIGHT - 1);
    l = clamp_row(y2, 0, wcsc_pkg::SCREEN_HEIGHT - 1);
    s.span_column = col;
    s.span_kind   = kind;
    s.visible     = (l >= f);
    s.y_first     = f[wcsc_pkg::Y_W-1:0];
    s.y_last      = l[wcsc_pkg::Y_W-1:0];
    s.last        = lst;
    expected_spans.push_back(s);
  endfunction

  function automatic void predict_column(input wcsc_pkg::item_t it);
    longint x1, x2, t, dx, top, bot, a, b, na, nb;
    int c;
    c  = int'(it.column);
    x1 = $signed(it.x_start);
    x2 = $signed(it.x_end);
    if (it.mode == wcsc_pkg::MODE_CLEAR) begin
      win_top[c] = '0;
      win_bot[c] = wcsc_pkg::YW'(wcsc_pkg::SCREEN_HEIGHT - 1);
      return;
    end
    if (it.mode != wcsc_pkg::MODE_SOLID && it.mode != wcsc_pkg::MODE_PORTAL) return;
    if (x1 >= x2 || c < x1 || c > x2) return;
    t   = c - x1;
    dx  = x2 - x1;
    top = win_top[c];
    bot = win_bot[c];
    a = clamp_row(lerp_height(t, dx, $signed(it.ceil_start), $signed(it.ceil_end)), top, bot);
    b = clamp_row(lerp_height(t, dx, $signed(it.floor_start), $signed(it.floor_end)),
                  top, bot);
    add_span(it.column, wcsc_pkg::KIND_CEIL, top, a - 1, 1'b0);
    add_span(it.column, wcsc_pkg::KIND_FLOOR, b + 1, bot, 1'b0);
    if (it.mode == wcsc_pkg::MODE_SOLID) begin
      add_span(it.column, wcsc_pkg::KIND_WALL, a, b, 1'b1);
    end else begin
      na = clamp_row(lerp_height(t, dx, $signed(it.nb_ceil_start), $signed(it.nb_ceil_end)),
                     top, bot);
      nb = clamp_row(lerp_height(t, dx, $signed(it.nb_floor_start), $signed(it.nb_floor_end)),
                     top, bot);
      add_span(it.column, wcsc_pkg::KIND_UPPER, a, na - 1, 1'b0);
      add_span(it.column, wcsc_pkg::KIND_LOWER, nb + 1, b, 1'b1);
      // narrow the window; it may end up inverted
      win_top[c] = wcsc_pkg::YW'(clamp_row((a > na) ? a : na, top,
                                           wcsc_pkg::SCREEN_HEIGHT - 1));
      win_bot[c] = wcsc_pkg::YW'(clamp_row((b < nb) ? b : nb, 0, bot));
    end
  endfunction

  function automatic wcsc_pkg::item_t wall(input logic [1:0] md, input int col, input int xs,
                                           input int xe, input int cs, input int ce,
                                           input int fs, input int fe, input int ncs,
                                           input int nce, input int nfs, input int nfe);
    wcsc_pkg::item_t it;
    it.mode           = md;
    it.column         = 10'(col);
    it.x_start        = 16'(xs);
    it.x_end          = 16'(xe);
    it.ceil_start     = 16'(cs);
    it.ceil_end       = 16'(ce);
    it.floor_start    = 16'(fs);
    it.floor_end      = 16'(fe);
    it.nb_ceil_start  = 16'(ncs);
    it.nb_ceil_end    = 16'(nce);
    it.nb_floor_start = 16'(nfs);
    it.nb_floor_end   = 16'(nfe);
    return it;
  endfunction

  function automatic int random_row();
    if ($urandom_range(9) == 0) return $signed(16'($urandom));
    return int'($urandom_range(1250)) - 100;
  endfunction

  function automatic wcsc_pkg::item_t random_wall(input logic [1:0] md);
    int col, lo, hi;
    col = ($urandom_range(3) == 0) ? $urandom_range(1023) : 500 + $urandom_range(7);
    lo  = ($urandom_range(7) == 0) ? 0 :
          $urandom_range(($urandom_range(3) == 0) ? 32000 : 300);
    hi  = ($urandom_range(7) == 0) ? 0 :
          $urandom_range(($urandom_range(3) == 0) ? 31000 : 300);
    if (lo == 0 && hi == 0) hi = 1;
    return wall(md, col, col - lo, col + hi, random_row(), random_row(), random_row(),
                random_row(), random_row(), random_row(), random_row(), random_row());
  endfunction

  function automatic wcsc_pkg::item_t random_noise();
    wcsc_pkg::item_t it;
    it.mode           = 2'($urandom_range(3));
    it.column         = 10'($urandom_range(1023));
    it.x_start        = 16'($urandom);
    it.x_end          = 16'($urandom);
    it.ceil_start     = 16'($urandom);
    it.ceil_end       = 16'($urandom);
    it.floor_start    = 16'($urandom);
    it.floor_end      = 16'($urandom);
    it.nb_ceil_start  = 16'($urandom);
    it.nb_ceil_end    = 16'($urandom);
    it.nb_floor_start = 16'($urandom);
    it.nb_floor_end   = 16'($urandom);
    return it;
  endfunction

  function automatic void queue_item(input wcsc_pkg::item_t it, input int idle, input int stall,
                                     input bit drain);
    pend_t p;
    p.it        = it;
    p.send_idle = idle;
    p.rcv_stall = stall;
    p.drain     = drain;
    pending.push_back(p);
  endfunction

  function automatic void log_mismatch(input string what, input wcsc_pkg::span_t want,
                                       input wcsc_pkg::span_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: expected col %0d kind %0d vis %0d rows %0d..%0d last %0d,",
                " got col %0d kind %0d vis %0d rows %0d..%0d last %0d"},
               $realtime, what, want.span_column, want.span_kind, want.visible, want.y_first,
               want.y_last, want.last, got.span_column, got.span_kind, got.visible,
               got.y_first, got.y_last, got.last);
  endfunction

  // Driver: hold the item while stalled, predict on acceptance, then fetch the next one.
  always @(posedge clk) begin
    logic nxt_valid;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      nxt_valid = item_valid;
      if (item_valid && !item_stall) begin
        predict_column(item);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending.size() > 0) begin
        if (!(pending[0].drain && expected_spans.size() != 0) &&
            $urandom_range(99) >= pending[0].send_idle) begin
          item <= pending[0].it;
          span_stall_pct = pending[0].rcv_stall;
          void'(pending.pop_front());
          nxt_valid = 1'b1;
        end
      end
      item_valid <= nxt_valid;
    end
  end

  // Monitor: check each accepted span item against the oldest prediction.
  always @(posedge clk) begin
    wcsc_pkg::span_t want;
    if (rst) begin
      span_stall <= 1'b0;
    end else begin
      if (span_valid && !span_stall) begin
        if (expected_spans.size() == 0) begin
          log_mismatch("unexpected span", '0, span);
        end else begin
          want = expected_spans.pop_front();
          if (span.span_column !== want.span_column || span.span_kind !== want.span_kind ||
              span.visible !== want.visible || span.y_first !== want.y_first ||
              span.y_last !== want.y_last || span.last !== want.last)
            log_mismatch("span mismatch", want, span);
        end
      end
      span_stall <= ($urandom_range(99) < span_stall_pct);
    end
  end

  initial begin
    int idle_pct [4];
    int stall_pct [4];
    int counted, r;
    idle_pct  = '{0, 63, 0, 32};
    stall_pct = '{0, 0, 63, 32};
    for (int i = 0; i < wcsc_pkg::SCREEN_WIDTH; i++) begin
      win_top[i] = '0;
      win_bot[i] = wcsc_pkg::YW'(wcsc_pkg::SCREEN_HEIGHT - 1);
    end

    // directed: column at both wall ends, field extremes, truncation, windows
    queue_item(wall(wcsc_pkg::MODE_SOLID, 0, 0, 1023, 100, 200, 900, 800, 0, 0, 0, 0),
               0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_SOLID, 1023, 0, 1023, 100, 200, 900, 800, 0, 0, 0, 0),
               0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_SOLID, 512, -32768, 32767, -32768, 32767, 32767, -32768,
                    0, 0, 0, 0), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_PORTAL, 513, -32768, 32767, 32767, -32768, -32768, 32767,
                    -32768, 32767, 32767, -32768), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_SOLID, 3, 0, 7, 10, 0, 20, 13, 0, 0, 0, 0), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_PORTAL, 4, 1, 8, 0, -9, -50, 1100, -7, -3, 2000, 5),
               0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_PORTAL, 100, 90, 110, 50, 70, 900, 880, 200, 220, 700,
                    720), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_SOLID, 100, 90, 110, 0, 0, 1023, 1023, 0, 0, 0, 0),
               0, 0, 0);
    // own ceiling below neighbour floor: the window turns inverted
    queue_item(wall(wcsc_pkg::MODE_PORTAL, 100, 99, 101, 600, 600, 650, 650, 250, 250, 300,
                    300), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_SOLID, 100, 0, 200, 10, 10, 1000, 1000, 0, 0, 0, 0),
               0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_CLEAR, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_SOLID, 100, 0, 200, 10, 10, 1000, 1000, 0, 0, 0, 0),
               0, 0, 0);
    queue_item(wall(MODE_UNUSED, 200, 0, 1023, 10, 10, 900, 900, 0, 0, 0, 0), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_SOLID, 300, 300, 300, 10, 10, 900, 900, 0, 0, 0, 0),
               0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_PORTAL, 300, 400, 200, 10, 10, 900, 900, 20, 20, 800,
                    800), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_SOLID, 300, 301, 900, 10, 10, 900, 900, 0, 0, 0, 0),
               0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_PORTAL, 300, 0, 299, 10, 10, 900, 900, 20, 20, 800, 800),
               0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_SOLID, 1, 0, 2, 0, 0, 1023, 1023, 0, 0, 0, 0), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_PORTAL, 2, 0, 5, 0, 0, 1023, 1023, -5000, -5000, 5000,
                    5000), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_CLEAR, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
    queue_item(wall(wcsc_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0);

    // random: mostly visible walls on a few shared columns, some clears and noise
    for (int ph = 0; ph < 4; ph++) begin
      counted = 0;
      while (counted < 18) begin
        r = $urandom_range(99);
        if (r < 40) begin
          queue_item(random_wall(wcsc_pkg::MODE_PORTAL), idle_pct[ph], stall_pct[ph],
                     counted == 0);
          counted++;
        end else if (r < 75) begin
          queue_item(random_wall(wcsc_pkg::MODE_SOLID), idle_pct[ph], stall_pct[ph],
                     counted == 0);
          counted++;
        end else if (r < 85) begin
          queue_item(wall(wcsc_pkg::MODE_CLEAR, 500 + $urandom_range(7), 0, 0, 0, 0, 0, 0,
                          0, 0, 0, 0),
                     idle_pct[ph], stall_pct[ph], counted == 0);
          counted++;
        end else begin
          queue_item(random_noise(), idle_pct[ph], stall_pct[ph], 1'b0);
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || item_valid) @(posedge clk);
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (mismatches == 0 && expected_spans.size() == 0) begin
      $display("wall_column_span_clipper_core test passed");
    end else begin
      $display("wall_column_span_clipper_core test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/wcsc_pkg.sv
sv/wall_column_span_clipper_core.sv
sv/wcsc_checker.sv
dv/testbench.sv
